FILE: rtl/i128_pkg.sv
`timescale 1ns / 1ps

package i128_pkg;

   localparam int unsigned WordBits = 64;
   localparam int unsigned DataBits = 128;
   localparam int unsigned LimbBits = 32;
   localparam int unsigned OpBits   = 3;

   typedef enum logic [OpBits-1:0] {
      OP_UDIV = 3'd0,
      OP_UREM = 3'd1,
      OP_SDIV = 3'd2,
      OP_SREM = 3'd3,
      OP_MUL  = 3'd4
   } opcode_type;

   // One transaction as it moves through the divide stages.
   typedef struct packed {
      logic                valid;
      logic [OpBits-1:0]   op;
      logic                neg_q;
      logic                neg_r;
      logic                div_zero;
      logic [DataBits-1:0] rem;
      logic [DataBits-1:0] num;
      logic [DataBits-1:0] den;
   } stage_type;

endpackage

FILE: rtl/i128_front.sv
`timescale 1ns / 1ps

module i128_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [i128_pkg::OpBits-1:0]        in_op,
   input  logic [i128_pkg::DataBits-1:0]      in_a,
   input  logic [i128_pkg::DataBits-1:0]      in_b,
   output i128_pkg::stage_type                out_stage
);

   localparam int unsigned L = i128_pkg::LimbBits;
   localparam int unsigned D = i128_pkg::DataBits;

   // stage A: input capture
   logic                          a_valid_ff;
   logic [i128_pkg::OpBits-1:0]   a_op_ff;
   logic [D-1:0]                  a_a_ff, a_b_ff;

   // stage B: operand magnitudes and partial products
   logic                          b_valid_ff;
   logic [i128_pkg::OpBits-1:0]   b_op_ff;
   logic                          b_neg_q_ff, b_neg_r_ff, b_dz_ff;
   logic [D-1:0]                  b_a_abs_ff, b_b_abs_ff;
   logic [2*L-1:0]                p00_ff, p01_ff, p10_ff, p02_ff, p11_ff, p20_ff;
   logic [2*L-1:0]                p03_ff, p12_ff, p21_ff, p30_ff;

   logic                          b_signed_in, b_neg_a_in, b_neg_b_in;
   logic [D-1:0]                  b_a_abs_in, b_b_abs_in;

   // stage C: column sums
   logic                          c_valid_ff;
   logic [i128_pkg::OpBits-1:0]   c_op_ff;
   logic                          c_neg_q_ff, c_neg_r_ff, c_dz_ff;
   logic [D-1:0]                  c_a_abs_ff, c_b_abs_ff;
   logic [2*L-1:0]                c_p00_ff;
   logic [2*L:0]                  c_s1_ff;
   logic [2*L-1:0]                c_s2_ff;
   logic [L-1:0]                  c_s3_ff;

   logic [D-1:0]                  prod_in;
   i128_pkg::stage_type           d_stage_in, d_stage_ff;

   always_comb begin
      b_signed_in = (a_op_ff == i128_pkg::OP_SDIV) || (a_op_ff == i128_pkg::OP_SREM);
      b_neg_a_in  = b_signed_in & a_a_ff[D-1];
      b_neg_b_in  = b_signed_in & a_b_ff[D-1];
      b_a_abs_in  = b_neg_a_in ? (~a_a_ff + 1'b1) : a_a_ff;
      b_b_abs_in  = b_neg_b_in ? (~a_b_ff + 1'b1) : a_b_ff;
   end

   always_comb begin
      prod_in = {{(2*L){1'b0}}, c_p00_ff}
              + {{(L-1){1'b0}}, c_s1_ff, {L{1'b0}}}
              + {c_s2_ff, {(2*L){1'b0}}}
              + {c_s3_ff, {(3*L){1'b0}}};
      d_stage_in          = '0;
      d_stage_in.valid    = c_valid_ff;
      d_stage_in.op       = c_op_ff;
      d_stage_in.neg_q    = c_neg_q_ff;
      d_stage_in.neg_r    = c_neg_r_ff;
      d_stage_in.div_zero = c_dz_ff;
      d_stage_in.num      = c_a_abs_ff;
      d_stage_in.den      = c_b_abs_ff;
      // carry the product in the remainder field; divide stages hold it
      d_stage_in.rem      = (c_op_ff == i128_pkg::OP_MUL) ? prod_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_stage_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_stage_ff.valid <= d_stage_in.valid;
      end
      a_op_ff <= in_op;
      a_a_ff  <= in_a;
      a_b_ff  <= in_b;

      b_op_ff    <= a_op_ff;
      b_neg_q_ff <= b_neg_a_in ^ b_neg_b_in;
      b_neg_r_ff <= b_neg_a_in;
      b_dz_ff    <= (a_b_ff == '0);
      b_a_abs_ff <= b_a_abs_in;
      b_b_abs_ff <= b_b_abs_in;
      p00_ff <= a_a_ff[L-1:0]     * a_b_ff[L-1:0];
      p01_ff <= a_a_ff[L-1:0]     * a_b_ff[2*L-1:L];
      p10_ff <= a_a_ff[2*L-1:L]   * a_b_ff[L-1:0];
      p02_ff <= a_a_ff[L-1:0]     * a_b_ff[3*L-1:2*L];
      p11_ff <= a_a_ff[2*L-1:L]   * a_b_ff[2*L-1:L];
      p20_ff <= a_a_ff[3*L-1:2*L] * a_b_ff[L-1:0];
      p03_ff <= a_a_ff[L-1:0]     * a_b_ff[4*L-1:3*L];
      p12_ff <= a_a_ff[2*L-1:L]   * a_b_ff[3*L-1:2*L];
      p21_ff <= a_a_ff[3*L-1:2*L] * a_b_ff[2*L-1:L];
      p30_ff <= a_a_ff[4*L-1:3*L] * a_b_ff[L-1:0];

      c_op_ff    <= b_op_ff;
      c_neg_q_ff <= b_neg_q_ff;
      c_neg_r_ff <= b_neg_r_ff;
      c_dz_ff    <= b_dz_ff;
      c_a_abs_ff <= b_a_abs_ff;
      c_b_abs_ff <= b_b_abs_ff;
      c_p00_ff   <= p00_ff;
      c_s1_ff    <= {1'b0, p01_ff} + {1'b0, p10_ff};
      // only the low 64 bits of this column reach the low 128 product bits
      c_s2_ff    <= p02_ff + p11_ff + p20_ff;
      c_s3_ff    <= p03_ff[L-1:0] + p12_ff[L-1:0] + p21_ff[L-1:0] + p30_ff[L-1:0];

      d_stage_ff.op       <= d_stage_in.op;
      d_stage_ff.neg_q    <= d_stage_in.neg_q;
      d_stage_ff.neg_r    <= d_stage_in.neg_r;
      d_stage_ff.div_zero <= d_stage_in.div_zero;
      d_stage_ff.rem      <= d_stage_in.rem;
      d_stage_ff.num      <= d_stage_in.num;
      d_stage_ff.den      <= d_stage_in.den;
   end

   assign out_stage = d_stage_ff;

endmodule

FILE: rtl/i128_div_stage.sv
`timescale 1ns / 1ps

module i128_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  i128_pkg::stage_type  in_stage,
   output i128_pkg::stage_type  out_stage
);

   localparam int unsigned D = i128_pkg::DataBits;

   logic [D-1:0]        shifted;
   logic [D:0]          diff;
   logic                take;
   i128_pkg::stage_type stage_in, stage_ff;

   always_comb begin
      shifted  = {in_stage.rem[D-2:0], in_stage.num[D-1]};
      diff     = {in_stage.rem[D-1], shifted} - {1'b0, in_stage.den};
      take     = ~diff[D];
      stage_in = in_stage;
      // multiply transactions pass untouched
      if (in_stage.op != i128_pkg::OP_MUL) begin
         stage_in.rem = take ? diff[D-1:0] : shifted;
         stage_in.num = {in_stage.num[D-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op       <= stage_in.op;
      stage_ff.neg_q    <= stage_in.neg_q;
      stage_ff.neg_r    <= stage_in.neg_r;
      stage_ff.div_zero <= stage_in.div_zero;
      stage_ff.rem      <= stage_in.rem;
      stage_ff.num      <= stage_in.num;
      stage_ff.den      <= stage_in.den;
   end

   assign out_stage = stage_ff;

endmodule

FILE: rtl/i128_back.sv
`timescale 1ns / 1ps

module i128_back (
   input  logic                            clock,
   input  logic                            reset,
   input  i128_pkg::stage_type             in_stage,
   output logic                            out_valid,
   output logic [i128_pkg::DataBits-1:0]   out_result
);

   localparam int unsigned D = i128_pkg::DataBits;

   logic [D-1:0] sel;
   logic         negate;
   logic [D-1:0] result_in, result_ff;
   logic         valid_ff;

   always_comb begin
      sel    = '0;
      negate = 1'b0;
      case (in_stage.op)
         i128_pkg::OP_UDIV: sel = in_stage.num;
         i128_pkg::OP_UREM: sel = in_stage.rem;
         i128_pkg::OP_SDIV: begin
            sel    = in_stage.num;
            negate = in_stage.neg_q;
         end
         i128_pkg::OP_SREM: begin
            sel    = in_stage.rem;
            negate = in_stage.neg_r;
         end
         i128_pkg::OP_MUL:  sel = in_stage.rem;
         default:           sel = '0;
      endcase
      result_in = negate ? (~sel + 1'b1) : sel;
      // drop divide results for a zero divisor
      if (in_stage.div_zero && in_stage.op != i128_pkg::OP_MUL) begin
         result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_stage.valid;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

FILE: rtl/int128_mul_div_rem_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        req_opcode, req_operand_a_lo/hi, req_operand_b_lo/hi
// response  out        rsp_valid (strobe)   rsp_result_lo, rsp_result_hi
//
// Every opcode takes the same path: four front stages (capture, magnitude and
// partial products, column sums, product sum), one stage per quotient bit (128), one
// output stage. One transaction is accepted every cycle; busy stays low.
// Reset (synchronous) clears only the valid bits; in-flight transactions are dropped.
// The receiver cannot stall, so the pipeline never holds.

module int128_mul_div_rem_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [i128_pkg::OpBits-1:0]         req_opcode,
   input  logic [i128_pkg::WordBits-1:0]       req_operand_a_lo,
   input  logic [i128_pkg::WordBits-1:0]       req_operand_a_hi,
   input  logic [i128_pkg::WordBits-1:0]       req_operand_b_lo,
   input  logic [i128_pkg::WordBits-1:0]       req_operand_b_hi,
   output logic                                rsp_valid,
   output logic [i128_pkg::WordBits-1:0]       rsp_result_lo,
   output logic [i128_pkg::WordBits-1:0]       rsp_result_hi
);

   localparam int unsigned D       = i128_pkg::DataBits;
   localparam int unsigned W       = i128_pkg::WordBits;
   localparam int unsigned Latency = 4 + D + 1;

   i128_pkg::stage_type stage [D+1];
   logic [D-1:0]        result;

   assign busy = 1'b0;

   i128_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_op     (req_opcode),
      .in_a      ({req_operand_a_hi, req_operand_a_lo}),
      .in_b      ({req_operand_b_hi, req_operand_b_lo}),
      .out_stage (stage[0])
   );

   for (genvar i = 0; i < D; i++) begin : g_div
      i128_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (stage[i]),
         .out_stage (stage[i+1])
      );
   end

   i128_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (stage[D]),
      .out_valid  (rsp_valid),
      .out_result (result)
   );

   assign rsp_result_lo = result[W-1:0];
   assign rsp_result_hi = result[D-1:W];

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Latency))
      else $error("response without a matching request");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_opcode, Latency) != i128_pkg::OP_UDIV
         && $past(req_opcode, Latency) != i128_pkg::OP_UREM
         && $past(req_opcode, Latency) != i128_pkg::OP_SDIV
         && $past(req_opcode, Latency) != i128_pkg::OP_SREM
         && $past(req_opcode, Latency) != i128_pkg::OP_MUL
      |-> (result == '0))
      else $error("unused opcode gave a nonzero result");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_operand_b_lo, Latency) == '0
         && $past(req_operand_b_hi, Latency) == '0
         && $past(req_opcode, Latency) != i128_pkg::OP_MUL
      |-> (result == '0))
      else $error("divide by zero gave a nonzero result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned Latency   = 133;
   localparam int unsigned CycleCap  = 400000;
   localparam int unsigned RandItems = 1750;

   typedef struct {
      logic [i128_pkg::WordBits-1:0] lo;
      logic [i128_pkg::WordBits-1:0] hi;
   } word_pair_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [i128_pkg::OpBits-1:0]   req_opcode;
   logic [i128_pkg::WordBits-1:0] req_operand_a_lo;
   logic [i128_pkg::WordBits-1:0] req_operand_a_hi;
   logic [i128_pkg::WordBits-1:0] req_operand_b_lo;
   logic [i128_pkg::WordBits-1:0] req_operand_b_hi;
   logic                          rsp_valid;
   logic [i128_pkg::WordBits-1:0] rsp_result_lo;
   logic [i128_pkg::WordBits-1:0] rsp_result_hi;

   word_pair_type expected_results[$];
   int unsigned   mismatch_count;
   int unsigned   cycle_count;
   int unsigned   idle_pct;

   int128_mul_div_rem_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_operand_a_lo (req_operand_a_lo),
      .req_operand_a_hi (req_operand_a_hi),
      .req_operand_b_lo (req_operand_b_lo),
      .req_operand_b_hi (req_operand_b_hi),
      .rsp_valid        (rsp_valid),
      .rsp_result_lo    (rsp_result_lo),
      .rsp_result_hi    (rsp_result_hi)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Arithmetic result for one transaction, built on native 128-bit vectors.
   function automatic logic [i128_pkg::DataBits-1:0] arith_result(
         logic [i128_pkg::OpBits-1:0] op,
         logic [i128_pkg::DataBits-1:0] a,
         logic [i128_pkg::DataBits-1:0] b);
      logic [i128_pkg::DataBits-1:0] mag_a;
      logic [i128_pkg::DataBits-1:0] mag_b;
      logic [i128_pkg::DataBits-1:0] quo;
      logic [i128_pkg::DataBits-1:0] rem;
      logic                          neg_a;
      logic                          neg_b;
      neg_a = a[i128_pkg::DataBits-1];
      neg_b = b[i128_pkg::DataBits-1];
      arith_result = '0;
      if (op == i128_pkg::OP_MUL) begin
         arith_result = a * b;
      end else if (op == i128_pkg::OP_UDIV || op == i128_pkg::OP_UREM) begin
         if (b != '0) arith_result = (op == i128_pkg::OP_UDIV) ? a / b : a % b;
      end else if (op == i128_pkg::OP_SDIV || op == i128_pkg::OP_SREM) begin
         mag_a = neg_a ? -a : a;
         mag_b = neg_b ? -b : b;
         if (mag_b != '0) begin
            quo = mag_a / mag_b;
            rem = mag_a % mag_b;
            if (op == i128_pkg::OP_SDIV) arith_result = (neg_a != neg_b) ? -quo : quo;
            else arith_result = neg_a ? -rem : rem;
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [i128_pkg::WordBits-1:0] got,
                                  logic [i128_pkg::WordBits-1:0] want);
      mismatch_count++;
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // Drive one transaction and hold it until the unit takes it.
   task automatic send_op(logic [i128_pkg::OpBits-1:0] op,
                          logic [i128_pkg::DataBits-1:0] a,
                          logic [i128_pkg::DataBits-1:0] b);
      logic [i128_pkg::DataBits-1:0] r;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_operand_a_lo <= a[63:0];
      req_operand_a_hi <= a[127:64];
      req_operand_b_lo <= b[63:0];
      req_operand_b_hi <= b[127:64];
      @(posedge clock);
      while (busy) @(posedge clock);
      r = arith_result(op, a, b);
      expected_results.push_back('{lo: r[63:0], hi: r[127:64]});
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      word_pair_type exp_item;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result lo", rsp_result_lo, '0);
         end else begin
            exp_item = expected_results.pop_front();
            if (rsp_result_lo !== exp_item.lo)
               report_mismatch("result_lo", rsp_result_lo, exp_item.lo);
            if (rsp_result_hi !== exp_item.hi)
               report_mismatch("result_hi", rsp_result_hi, exp_item.hi);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleCap) begin
         $display("int128_mul_div_rem_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [i128_pkg::DataBits-1:0] rand_word128();
      logic [i128_pkg::DataBits-1:0] v;
      int unsigned                   shift;
      v = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(7))
         0: v = '0;
         1: v = '1;
         2: v = {1'b1, 127'b0};
         3: v = {1'b0, {127{1'b1}}};
         4: begin
            shift = $urandom_range(127);
            v = v >> shift;
         end
         5: v = -(v >> $urandom_range(127));
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_extremes();
      logic [i128_pkg::DataBits-1:0] min_val;
      logic [i128_pkg::DataBits-1:0] max_val;
      logic [i128_pkg::DataBits-1:0] all_ones;
      min_val  = {1'b1, 127'b0};
      max_val  = {1'b0, {127{1'b1}}};
      all_ones = '1;
      idle_pct = 0;
      for (int op = i128_pkg::OP_UDIV; op <= i128_pkg::OP_MUL; op++) begin
         send_op(i128_pkg::OpBits'(op), all_ones, 128'd7);
         send_op(i128_pkg::OpBits'(op), min_val, all_ones);
         send_op(i128_pkg::OpBits'(op), max_val, '0);
         send_op(i128_pkg::OpBits'(op), -128'd77, 128'd5);
      end
      send_op(i128_pkg::OP_SREM, min_val, all_ones);
      send_op(i128_pkg::OP_SDIV, 128'd77, -128'd5);
      send_op(i128_pkg::OP_MUL, all_ones, all_ones);
      send_op(3'd5, all_ones, all_ones);
      send_op(3'd6, 128'd1, 128'd1);
      send_op(3'd7, min_val, max_val);
   endtask

   task automatic test_random(int unsigned count, int unsigned pct);
      logic [i128_pkg::OpBits-1:0] op;
      idle_pct = pct;
      repeat (count) begin
         op = ($urandom_range(15) == 0) ? i128_pkg::OpBits'($urandom_range(7, 5))
                                        : i128_pkg::OpBits'($urandom_range(4));
         send_op(op, rand_word128(), rand_word128());
      end
   endtask

   initial begin
      mismatch_count   = 0;
      cycle_count      = 0;
      idle_pct         = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = '0;
      req_operand_a_lo = '0;
      req_operand_a_hi = '0;
      req_operand_b_lo = '0;
      req_operand_b_hi = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_random(RandItems / 4, 0);
      test_random(RandItems / 4, 65);
      test_random(RandItems / 4, 14);
      test_random(RandItems / 4, 0);
      start <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("int128_mul_div_rem_unit: match");
      end else begin
         $display("int128_mul_div_rem_unit: mismatch");
      end
      $finish;
   end

endmodule
